>>> rtl/core/ckp_pkg.sv
package ckp_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_POINTS = 128;
    localparam int DEF_FRAC_BITS  = 16;

    // one memory row holds a whole control point
    localparam int ROW_WORDS  = 7;
    localparam int WORD_W     = 32;
    localparam int WORD_SPEED = 6;
    localparam int WORD_LAST_POSE = 5;

    // datapath widths
    localparam int MUL_A_W = 34;
    localparam int PROD_W  = 66;
    localparam int POLY_W  = 36;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // register index (address bit 2 selects the register)
    localparam logic REG_POINT_COUNT = 1'b0;
    localparam logic [7:0] POINT_COUNT_RST = 8'd4;

    typedef logic [ROW_WORDS-1:0][WORD_W-1:0] t_row;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_RD,
        S_POW,
        S_COEF,
        S_MUL,
        S_PHM,
        S_OUT
    } t_state;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(32'sh7fffffff);
        lo = ~hi;
        if (v > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[WORD_W-1:0];
        end
    endfunction

    // clamp a spline coefficient to +-(2^32-1)
    function automatic logic signed [MUL_A_W-1:0] clamp_coef(
        input logic signed [POLY_W-1:0] v);
        logic signed [POLY_W-1:0] lim;
        lim = POLY_W'(34'sh0ffffffff);
        if (v > lim) begin
            clamp_coef = MUL_A_W'(lim);
        end else if (v < -lim) begin
            clamp_coef = MUL_A_W'(-lim);
        end else begin
            clamp_coef = v[MUL_A_W-1:0];
        end
    endfunction

endpackage

>>> rtl/core/ckp_if.sv
// request channel: loads and ticks
interface ckp_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic        [6:0]  point_index;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_pos_z;
    logic signed [31:0] load_dir_x;
    logic signed [31:0] load_dir_y;
    logic signed [31:0] load_dir_z;
    logic signed [31:0] load_speed;
    logic        [30:0] time_step;

    modport source (output valid, operation, point_index, load_pos_x, load_pos_y,
                    load_pos_z, load_dir_x, load_dir_y, load_dir_z, load_speed,
                    time_step, input ready);
    modport sink (input valid, operation, point_index, load_pos_x, load_pos_y,
                  load_pos_z, load_dir_x, load_dir_y, load_dir_z, load_speed,
                  time_step, output ready);
endinterface

// result channel: pose after each tick
interface ckp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_z;
    logic signed [31:0] view_x;
    logic signed [31:0] view_y;
    logic signed [31:0] view_z;
    logic               moved;
    logic        [6:0]  segment;

    modport source (output valid, pose_x, pose_y, pose_z, view_x, view_y, view_z,
                    moved, segment, input ready);
    modport sink (input valid, pose_x, pose_y, pose_z, view_x, view_y, view_z,
                  moved, segment, output ready);
endinterface

>>> rtl/core/ckp_point_mem.sv
module ckp_point_mem #(
    parameter int DEPTH = ckp_pkg::DEF_MAX_POINTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  ckp_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_waddr,
    input  ckp_pkg::t_row     i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output ckp_pkg::t_row     o_rdata
);
    import ckp_pkg::*;

    t_row r_mem [DEPTH];
    t_row r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ckp_mul.sv
module ckp_mul (
    input  logic                                  i_clk,
    input  logic signed [ckp_pkg::MUL_A_W-1:0]    i_a,
    input  logic signed [ckp_pkg::WORD_W-1:0]     i_b,
    output logic signed [ckp_pkg::PROD_W-1:0]     o_prod
);
    import ckp_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // shared multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/core/catmull_rom_keyframe_path.sv
// Channel  Dir  Handshake      Carries
// i_cmd    in   valid/ready    load of one control point, or a time tick
// o_pose   out  valid/ready    pose, view, moved flag and segment per tick
// APB      in   psel/penable   point_count at byte address 0
//
// A load is written straight into the point memory in the cycle it is accepted.
// A tick holds off the next request until it is done: an index step, plus
// subtraction steps if point_count was lowered below the segment, the four
// row reads, t^2/t^3, a spline evaluation of speed and the phase update; when
// the pose is recomputed, t^2/t^3 again and spline evaluations of the six pose
// words follow, all on the one shared multiplier.
// Synchronous active-low reset clears control, phase, segment and held pose;
// the point memory is undefined until loaded. A finished pose waits in the
// output register while the next request is taken; a second finished pose
// waits in S_OUT until that register drains.
module catmull_rom_keyframe_path #(
    parameter int MAX_POINTS = ckp_pkg::DEF_MAX_POINTS,
    parameter int FRAC_BITS  = ckp_pkg::DEF_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ckp_in_if.sink      i_cmd,
    ckp_out_if.source   o_pose,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ckp_pkg::*;

    localparam int PW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam logic signed [WORD_W-1:0] ONE_Q = WORD_W'(1) << FRAC_BITS;

    t_state r_state, n_state;
    logic [2:0] r_cnt;
    logic [2:0] r_word;
    logic [7:0] r_point_count;
    logic [NW-1:0] r_n;
    logic [PW-1:0] r_seg, r_segidx;
    logic [PW-1:0] r_idx [4];
    logic [30:0] r_ts;
    logic signed [WORD_W-1:0] r_phase, r_t2, r_t3, r_spd;
    logic signed [MUL_A_W-1:0] r_cb, r_cc, r_cd;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [WORD_W-1:0] r_held [6];
    logic r_moved;
    t_row r_pt [4];
    logic r_ovalid;
    logic signed [WORD_W-1:0] r_opose [6];
    logic r_omoved;
    logic [6:0] r_oseg;

    t_mem_ctl mem_ctl;
    logic [PW-1:0] mem_raddr, mem_waddr;
    t_row mem_wdata, mem_rdata;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [WORD_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic take, cfg_wr, slot_ok, out_free;

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POINT_COUNT);
    assign prdata = (paddr[2] == REG_POINT_COUNT) ? {24'd0, r_point_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= POINT_COUNT_RST;
        end else if (cfg_wr) begin
            r_point_count <= pwdata[7:0];
        end
    end

    // handshake
    assign take     = i_cmd.valid && i_cmd.ready;
    assign slot_ok  = 32'(i_cmd.point_index) < 32'(MAX_POINTS);
    assign out_free = !r_ovalid || o_pose.ready;

    ckp_point_mem #(.DEPTH(MAX_POINTS), .AW(PW)) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ckp_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign mem_waddr = PW'(32'(i_cmd.point_index));
    assign mem_wdata = {i_cmd.load_speed, i_cmd.load_dir_z, i_cmd.load_dir_y,
                        i_cmd.load_dir_x, i_cmd.load_pos_z, i_cmd.load_pos_y,
                        i_cmd.load_pos_x};

    // spline arithmetic on the word being evaluated
    logic signed [POLY_W-1:0] p1, p2, p3, p4;
    logic signed [PROD_W-1:0] term, acc_sum, ph_sum;
    logic signed [WORD_W-1:0] res, pn, pn_sub;
    logic [PW-1:0] idx2, idx3;

    always_comb begin
        p1 = POLY_W'(signed'(r_pt[0][r_word]));
        p2 = POLY_W'(signed'(r_pt[1][r_word]));
        p3 = POLY_W'(signed'(r_pt[2][r_word]));
        p4 = POLY_W'(signed'(r_pt[3][r_word]));
        term    = prod >>> FRAC_BITS;
        acc_sum = r_acc + term;
        res     = sat32(acc_sum >>> 1);
        ph_sum  = PROD_W'(r_phase) + term;
        pn      = sat32(ph_sum);
        pn_sub  = sat32(PROD_W'(pn) - PROD_W'(ONE_Q));
        idx2    = (NW'(r_seg) + NW'(1) == r_n) ? '0 : r_seg + PW'(1);
        idx3    = (NW'(idx2) + NW'(1) == r_n) ? '0 : idx2 + PW'(1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (take && i_cmd.operation == OP_TICK) n_state = S_MOD;
            S_MOD:  if (NW'(r_seg) < r_n) n_state = S_RD;
            S_RD:   if (r_cnt == 3'd4) n_state = S_POW;
            S_POW:  if (r_cnt == 3'd3) n_state = S_COEF;
            S_COEF: n_state = S_MUL;
            S_MUL: begin
                if (r_cnt == 3'd3) begin
                    if (r_word == 3'(WORD_SPEED)) n_state = S_PHM;
                    else if (r_word == 3'(WORD_LAST_POSE)) n_state = S_OUT;
                    else n_state = S_COEF;
                end
            end
            S_PHM: begin
                if (r_cnt == 3'd1) n_state = (pn <= ONE_Q) ? S_POW : S_OUT;
            end
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer: request ready, memory control and multiplier operands
    always_comb begin
        i_cmd.ready = 1'b0;
        mem_ctl     = '0;
        mem_raddr   = r_idx[0];
        mul_a       = '0;
        mul_b       = '0;
        unique case (r_state)
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                mem_ctl.we  = take && i_cmd.operation == OP_LOAD && slot_ok;
            end
            S_RD: begin
                mem_ctl.re = r_cnt < 3'd4;
                mem_raddr  = r_idx[r_cnt[1:0]];
            end
            S_POW: begin
                mul_a = MUL_A_W'(r_phase);
                mul_b = (r_cnt == 3'd2) ? r_t2 : r_phase;
            end
            S_MUL: begin
                unique case (r_cnt)
                    3'd0: begin mul_a = r_cb; mul_b = r_phase; end
                    3'd1: begin mul_a = r_cc; mul_b = r_t2; end
                    default: begin mul_a = r_cd; mul_b = r_t3; end
                endcase
            end
            S_PHM: begin
                mul_a = MUL_A_W'({1'b0, r_ts});
                mul_b = r_spd;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_word   <= '0;
            r_phase  <= '0;
            r_segidx <= '0;
            r_moved  <= 1'b0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 6; k++) r_held[k] <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? 3'd0 : r_cnt + 3'd1;
            if (r_state == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (o_pose.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: r_word <= 3'(WORD_SPEED);
                S_MUL: begin
                    if (r_cnt == 3'd3) begin
                        if (r_word == 3'(WORD_SPEED)) begin
                            r_spd <= res;
                        end else begin
                            r_held[r_word] <= res;
                            r_word <= r_word + 3'd1;
                        end
                    end
                end
                S_PHM: begin
                    if (r_cnt == 3'd1) begin
                        if (pn <= ONE_Q) begin
                            r_phase  <= pn;
                            r_segidx <= r_seg;
                            r_moved  <= 1'b1;
                            r_word   <= '0;
                        end else begin
                            r_phase  <= pn_sub;
                            r_segidx <= r_idx[2];
                            r_moved  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    r_ts  <= i_cmd.time_step;
                    r_seg <= r_segidx;
                    if (r_point_count == 8'd0) r_n <= NW'(1);
                    else if (32'(r_point_count) > 32'(MAX_POINTS)) r_n <= NW'(MAX_POINTS);
                    else r_n <= NW'(r_point_count);
                end
            end
            S_MOD: begin
                if (NW'(r_seg) >= r_n) begin
                    r_seg <= PW'(NW'(r_seg) - r_n);
                end else begin
                    r_idx[0] <= (r_seg == '0) ? PW'(r_n - NW'(1)) : r_seg - PW'(1);
                    r_idx[1] <= r_seg;
                    r_idx[2] <= idx2;
                    r_idx[3] <= idx3;
                end
            end
            S_RD: if (r_cnt != 3'd0) r_pt[r_cnt[1:0] - 2'd1] <= mem_rdata;
            S_POW: begin
                if (r_cnt == 3'd1) r_t2 <= sat32(term);
                if (r_cnt == 3'd3) r_t3 <= sat32(term);
            end
            S_COEF: begin
                r_cb  <= clamp_coef(p3 - p1);
                r_cc  <= clamp_coef((p1 <<< 1) - (p2 <<< 2) - p2 + (p3 <<< 2) - p4);
                r_cd  <= clamp_coef(-p1 + (p2 <<< 1) + p2 - (p3 <<< 1) - p3 + p4);
                r_acc <= PROD_W'(p2) <<< 1;
            end
            S_MUL: if (r_cnt != 3'd0) r_acc <= acc_sum;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            for (int k = 0; k < 6; k++) r_opose[k] <= r_held[k];
            r_omoved <= r_moved;
            r_oseg   <= 7'(r_segidx);
        end
    end

    assign o_pose.valid   = r_ovalid;
    assign o_pose.pose_x  = r_opose[0];
    assign o_pose.pose_y  = r_opose[1];
    assign o_pose.pose_z  = r_opose[2];
    assign o_pose.view_x  = r_opose[3];
    assign o_pose.view_y  = r_opose[4];
    assign o_pose.view_z  = r_opose[5];
    assign o_pose.moved   = r_omoved;
    assign o_pose.segment = r_oseg;

    // wrapped neighbour indices stay on the path while rows are read
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |-> (NW'(r_idx[0]) < r_n) && (NW'(r_idx[3]) < r_n))
        else $error("neighbour index beyond point count");

    // segment handed out is always on the path
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> NW'(r_segidx) < r_n)
        else $error("segment beyond point count");

    // a segment advance re-emits the held pose untouched (pose_x and view_x checked)
    a_held_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_moved && $past(r_state) == S_PHM) |->
        $stable(r_held[0]) && $stable(r_held[3]))
        else $error("held pose changed on segment advance");

endmodule
